/* hw/rtl/swrc_pkg.sv */
// Shared types and constants for the sliding-window request counter.
`timescale 1ns / 1ps
package swrc_pkg;
	localparam int TableEntriesDef    = 16;
	localparam int BucketsPerEntryDef = 64;
	localparam int CountBitsDef       = 16;
	localparam int AddrW   = 32;
	localparam int TimeW   = 32;
	localparam int WinW    = 6;
	localparam int ResultW = 16;
	localparam logic [WinW-1:0] WinReset = 6'd60;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_COUNT = 2'd1,
		CMD_SWEEP = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // latch input beat
		logic scan_clr;  // reset entry scan index
		logic scan_inc;  // advance entry scan index
		logic pick;      // latch scan index as working entry
		logic alloc;     // allocate working entry at free slot
		logic brd;       // issue bucket read at head
		logic drop;      // drop oldest bucket
		logic sum_clr;
		logic sum_rd;    // issue read at ring offset k
		logic sum_acc;   // accumulate read data
		logic bump;      // increment newest bucket
		logic append;    // write a new bucket
		logic touch;     // write last access
		logic evict;     // sweep check at scan index
		logic set_full;
		logic set_cnt;
	} swrc_cmd_t;

	typedef struct packed {
		cmd_t op;
		logic scan_last;
		logic hit;       // scan entry matches address
		logic free;      // scan entry is free
		logic fill_zero;
		logic head_old;  // bucket read data expired
		logic tail_now;  // bucket read data time equals now
		logic sum_last;
	} swrc_sts_t;
endpackage

/* hw/rtl/swrc_if.sv */
// Valid/ready channel interface.
`timescale 1ns / 1ps
interface swrc_if #(parameter int W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/swrc_ctrl.sv */
// Controller state machine for the sliding-window request counter.
`timescale 1ns / 1ps
module swrc_ctrl import swrc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  swrc_sts_t sts,
	output swrc_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_ALLOC, S_HRD, S_HCHK, S_TRD, S_TCHK,
		S_SRD, S_SACC, S_SWEEP, S_DONE
	} state_t;
	state_t state_q;
	logic   found_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.scan_clr = in_valid;
			end
			S_FIND: begin
				if (sts.op == CMD_SWEEP) begin
				end else if (sts.hit) begin
					cmd.pick = 1'b1;
				end else begin
					cmd.scan_inc = !sts.scan_last;
				end
				if (sts.op == CMD_ADD && !sts.hit && sts.scan_last) cmd.scan_clr = 1'b1;
			end
			S_ALLOC: begin
				if (sts.free) cmd.alloc = 1'b1;
				else if (sts.scan_last) cmd.set_full = 1'b1;
				else cmd.scan_inc = 1'b1;
			end
			S_HRD: cmd.brd = !sts.fill_zero;
			S_HCHK: cmd.drop = sts.head_old;
			S_TRD: cmd.sum_clr = 1'b1;
			S_TCHK: begin
				if (sts.op == CMD_ADD) begin
					if (!sts.fill_zero && sts.tail_now) cmd.bump = 1'b1;
					else cmd.append = 1'b1;
					cmd.touch = 1'b1;
				end else if (!sts.fill_zero) begin
					cmd.touch = 1'b1;
					cmd.sum_rd = 1'b1;
				end
			end
			S_SRD: cmd.sum_rd = 1'b1;
			S_SACC: begin
				cmd.sum_acc = 1'b1;
				cmd.set_cnt = sts.sum_last;
				cmd.sum_rd = !sts.sum_last;
			end
			S_SWEEP: begin
				cmd.evict = 1'b1;
				cmd.scan_inc = !sts.scan_last;
			end
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_FIND;
				S_FIND: begin
					found_q <= sts.hit;
					if (sts.op == CMD_SWEEP) state_q <= S_SWEEP;
					else if (sts.op == CMD_NOP) state_q <= S_DONE;
					else if (sts.hit) state_q <= S_HRD;
					else if (sts.scan_last)
						state_q <= (sts.op == CMD_ADD) ? S_ALLOC : S_DONE;
				end
				S_ALLOC: begin
					if (sts.free) state_q <= S_HRD;
					else if (sts.scan_last) state_q <= S_DONE;
				end
				S_HRD: state_q <= sts.fill_zero ? S_TRD : S_HCHK;
				S_HCHK: state_q <= sts.head_old ? S_HRD : S_TRD;
				S_TRD: state_q <= S_TCHK;
				S_TCHK: begin
					if (sts.op == CMD_ADD || sts.fill_zero) state_q <= S_DONE;
					else state_q <= S_SACC;
				end
				S_SRD: state_q <= S_SACC;
				S_SACC: if (sts.sum_last) state_q <= S_DONE;
				S_SWEEP: if (sts.scan_last) state_q <= S_DONE;
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.bump && cmd.append)) else $error("bump and append together");
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid) else $error("result lost");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !cmd.load) else $error("load while busy");
	a_found_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HRD && $past(state_q) == S_FIND) |-> found_q)
		else $error("bucket walk without hit");
endmodule

/* hw/rtl/swrc_dp.sv */
// Datapath: entry table, bucket memories, ring pointers and the sum.
`timescale 1ns / 1ps
module swrc_dp import swrc_pkg::*; #(
	parameter int TABLE_ENTRIES     = TableEntriesDef,
	parameter int BUCKETS_PER_ENTRY = BucketsPerEntryDef,
	parameter int COUNT_BITS        = CountBitsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  swrc_cmd_t          cmd,
	output swrc_sts_t          sts,
	input  logic [1:0]         in_command,
	input  logic [AddrW-1:0]   in_address,
	input  logic [TimeW-1:0]   in_now,
	input  logic               cfg_we,
	input  logic [WinW-1:0]    cfg_data,
	output logic [ResultW-1:0] res_count,
	output logic               res_status
);
	localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int BW = $clog2(BUCKETS_PER_ENTRY);
	localparam int FW = $clog2(BUCKETS_PER_ENTRY + 1);
	localparam int MW = EW + BW;
	localparam int MD = TABLE_ENTRIES * BUCKETS_PER_ENTRY;
	localparam int SW = COUNT_BITS + FW;
	localparam logic [COUNT_BITS-1:0] CntMax = '1;
	localparam logic [EW-1:0] LastE = EW'(TABLE_ENTRIES - 1);
	localparam logic [FW-1:0] FullF = FW'(BUCKETS_PER_ENTRY);

	logic [WinW-1:0]  win_q;
	logic [1:0]       op_q;
	logic [AddrW-1:0] addr_q;
	logic [TimeW-1:0] now_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [AddrW-1:0] eaddr_q [TABLE_ENTRIES];
	logic [TimeW-1:0] elast_q [TABLE_ENTRIES];
	logic [BW-1:0]    head_q  [TABLE_ENTRIES];
	logic [FW-1:0]    fill_q  [TABLE_ENTRIES];
	logic [EW-1:0]    scan_q, ent_q;
	logic [FW-1:0]    k_q;
	logic [SW-1:0]    sum_q;
	logic [ResultW-1:0] cnt_q;
	logic             full_q;

	logic [TimeW-1:0]      btime_mem [MD];
	logic [COUNT_BITS-1:0] bcnt_mem  [MD];
	logic [TimeW-1:0]      rtime_q;
	logic [COUNT_BITS-1:0] rcnt_q;
	logic [MW-1:0]         raddr, waddr;
	logic                  mem_re, mem_we;
	logic [TimeW-1:0]      wtime;
	logic [COUNT_BITS-1:0] wcnt;

	function automatic logic is_old(input logic [TimeW-1:0] t, input logic [TimeW-1:0] n,
			input logic [WinW-1:0] w);
		return (n >= t) && ((n - t) > TimeW'(w));
	endfunction

	function automatic logic [MW-1:0] slot(input logic [EW-1:0] e, input logic [BW-1:0] h,
			input logic [FW-1:0] k);
		logic [FW:0] s;
		s = (FW+1)'(h) + (FW+1)'(k);
		if (s >= (FW+1)'(BUCKETS_PER_ENTRY)) s = s - (FW+1)'(BUCKETS_PER_ENTRY);
		return MW'(e) * MW'(BUCKETS_PER_ENTRY) + MW'(s);
	endfunction

	logic [FW-1:0] fill_e;
	logic [BW-1:0] head_e;
	logic [FW-1:0] tail_k;
	assign fill_e = fill_q[ent_q];
	assign head_e = head_q[ent_q];
	assign tail_k = fill_e - FW'(1);

	// One read port: head during drop, tail for the add, offset k for the sum.
	always_comb begin
		mem_re = cmd.brd || cmd.sum_clr || cmd.sum_rd;
		if (cmd.brd) raddr = slot(ent_q, head_e, '0);
		else if (cmd.sum_clr) raddr = slot(ent_q, head_e, tail_k);
		else raddr = slot(ent_q, head_e, cmd.sum_acc ? k_q + FW'(1) : k_q);
	end

	logic [BW-1:0] head_app;
	logic [FW-1:0] fill_app;
	always_comb begin
		head_app = head_e;
		fill_app = fill_e;
		if (fill_e >= FullF) begin
			head_app = (head_e == BW'(BUCKETS_PER_ENTRY - 1)) ? '0 : head_e + BW'(1);
			fill_app = fill_e - FW'(1);
		end
		mem_we = cmd.bump || cmd.append;
		waddr  = cmd.bump ? slot(ent_q, head_e, tail_k) : slot(ent_q, head_app, fill_app);
		wtime  = now_q;
		wcnt   = cmd.bump ? ((rcnt_q == CntMax) ? rcnt_q : rcnt_q + COUNT_BITS'(1))
			: COUNT_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			btime_mem[waddr] <= wtime;
			bcnt_mem[waddr]  <= wcnt;
		end
		if (mem_re) begin
			rtime_q <= btime_mem[raddr];
			rcnt_q  <= bcnt_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_command;
			addr_q <= in_address;
			now_q  <= in_now;
		end
		if (cmd.alloc) eaddr_q[scan_q] <= addr_q;
		if (cmd.touch) elast_q[ent_q] <= now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= WinReset;
			valid_q <= '0;
			scan_q  <= '0;
			ent_q   <= '0;
			k_q     <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			full_q  <= 1'b0;
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				head_q[i] <= '0;
				fill_q[i] <= '0;
			end
		end else begin
			if (cfg_we) win_q <= cfg_data;
			if (cmd.load) begin
				cnt_q  <= '0;
				full_q <= 1'b0;
			end
			if (cmd.scan_clr) scan_q <= '0;
			else if (cmd.scan_inc) scan_q <= scan_q + EW'(1);
			if (cmd.pick) ent_q <= scan_q;
			if (cmd.alloc) begin
				ent_q <= scan_q;
				valid_q[scan_q] <= 1'b1;
				head_q[scan_q] <= '0;
				fill_q[scan_q] <= '0;
			end
			if (cmd.drop) begin
				head_q[ent_q] <= (head_e == BW'(BUCKETS_PER_ENTRY - 1)) ? '0 : head_e + BW'(1);
				fill_q[ent_q] <= fill_e - FW'(1);
			end
			if (cmd.append) begin
				head_q[ent_q] <= head_app;
				fill_q[ent_q] <= fill_app + FW'(1);
			end
			if (cmd.evict && valid_q[scan_q] && is_old(elast_q[scan_q], now_q, win_q)) begin
				valid_q[scan_q] <= 1'b0;
				head_q[scan_q]  <= '0;
				fill_q[scan_q]  <= '0;
			end
			if (cmd.sum_clr) begin
				sum_q <= '0;
				k_q   <= '0;
			end else if (cmd.sum_acc) begin
				sum_q <= sum_q + SW'(rcnt_q);
				k_q   <= k_q + FW'(1);
			end
			if (cmd.set_full) full_q <= 1'b1;
			if (cmd.set_cnt) begin
				if (sum_q + SW'(rcnt_q) > SW'(16'hFFFF)) cnt_q <= '1;
				else cnt_q <= ResultW'(sum_q + SW'(rcnt_q));
			end
		end
	end

	always_comb begin
		sts.op        = cmd_t'(op_q);
		sts.scan_last = (scan_q == LastE);
		sts.hit       = valid_q[scan_q] && (eaddr_q[scan_q] == addr_q);
		sts.free      = !valid_q[scan_q];
		sts.fill_zero = (fill_e == '0);
		sts.head_old  = is_old(rtime_q, now_q, win_q);
		sts.tail_now  = (rtime_q == now_q);
		sts.sum_last  = (k_q + FW'(1) >= fill_e);
	end

	assign res_count  = cnt_q;
	assign res_status = full_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q[ent_q] <= FullF) else $error("ring overfilled");
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !valid_q[scan_q]) else $error("alloc on used slot");
	a_alloc_sets: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |=> valid_q[$past(scan_q)]) else $error("alloc lost");
endmodule

/* hw/rtl/sliding_window_request_counter.sv */
// Top level of the sliding-window request counter.
// Channels: req (command, address, now) in, rsp (count, status) out,
// cfg carries time_window. All are valid/ready; a beat moves when both high.
// One item is worked at a time: req is ready only when the block is idle.
// Steps: a table search of up to TABLE_ENTRIES entries, plus up to
// TABLE_ENTRIES more when an add has to find a free slot, plus a bucket
// read and a check per dropped bucket, plus a count summed one bucket
// per cycle through the single bucket memory read port. A sweep walks all
// entries, one per cycle.
// The response is held in registers until rsp.ready; req stays blocked
// while the receiver stalls.
// Reset clears every entry's valid bit and ring pointers and sets the
// window to 60 seconds; bucket memories need no clearing pass.
// Write cfg only while no request is in flight.
`timescale 1ns / 1ps
module sliding_window_request_counter import swrc_pkg::*; #(
	parameter int TABLE_ENTRIES     = TableEntriesDef,
	parameter int BUCKETS_PER_ENTRY = BucketsPerEntryDef,
	parameter int COUNT_BITS        = CountBitsDef
) (
	input logic clk,
	input logic arst_n,
	swrc_if.sink   req,
	swrc_if.source rsp,
	swrc_if.sink   cfg
);
	swrc_cmd_t cmd;
	swrc_sts_t sts;

	assign cfg.ready = 1'b1;

	swrc_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (req.valid), .in_ready (req.ready),
		.out_valid (rsp.valid), .out_ready (rsp.ready),
		.sts, .cmd
	);

	swrc_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.BUCKETS_PER_ENTRY (BUCKETS_PER_ENTRY),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.in_command (req.data[65:64]),
		.in_address (req.data[63:32]),
		.in_now     (req.data[31:0]),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.data[WinW-1:0]),
		.res_count  (rsp.data[16:1]),
		.res_status (rsp.data[0])
	);
endmodule

/* tb/sv/sliding_window_request_counter_test.sv */
// Testbench for the sliding-window request counter: random and directed requests against a predictor.
`timescale 1ns / 1ps
module sliding_window_request_counter_test;
	import swrc_pkg::*;

	localparam int NumEntries = 16;
	localparam int RingDepth  = 64;
	localparam int CountMax   = 65535;
	localparam int CycleLimit = 2000000;

	typedef struct packed {
		logic [ResultW-1:0] count;
		logic               status;
	} tally_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swrc_if #(2 + AddrW + TimeW) req_ch ();
	swrc_if #(ResultW + 1)       rsp_ch ();
	swrc_if #(WinW)              cfg_ch ();

	sliding_window_request_counter uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	always #4 clk = ~clk;

	// tracker state as the block should hold it
	logic [WinW-1:0]  win;
	bit               trk_valid [NumEntries];
	logic [AddrW-1:0] trk_addr [NumEntries];
	logic [TimeW-1:0] trk_seen [NumEntries];
	logic [TimeW-1:0] bkt_sec [NumEntries][RingDepth];
	int               bkt_hits [NumEntries][RingDepth];
	int               ring_first [NumEntries];
	int               ring_len [NumEntries];

	tally_t           tally_q[$];
	int               errors = 0;
	int               cycles = 0;
	int               burst_left = 0;
	int               hold_cycles = 0;
	logic [TimeW-1:0] clock_s = 32'd1000;
	logic [AddrW-1:0] addr_pool [24];

	task automatic report(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic bit is_stale(input logic [TimeW-1:0] t, input logic [TimeW-1:0] n);
		logic [TimeW-1:0] age;
		age = (n >= t) ? n - t : '0;
		return age > win;
	endfunction

	function automatic int lookup(input logic [AddrW-1:0] a);
		for (int e = 0; e < NumEntries; e++)
			if (trk_valid[e] && trk_addr[e] == a)
				return e;
		return -1;
	endfunction

	function automatic int slot(input int e, input int k);
		return (ring_first[e] + k) % RingDepth;
	endfunction

	function automatic void trim(input int e, input logic [TimeW-1:0] n);
		while (ring_len[e] > 0 && is_stale(bkt_sec[e][slot(e, 0)], n)) begin
			ring_first[e] = (ring_first[e] + 1) % RingDepth;
			ring_len[e]--;
		end
	endfunction

	function automatic tally_t tally_of(input cmd_t op, input logic [AddrW-1:0] a,
			input logic [TimeW-1:0] n);
		tally_t r;
		int e, s;
		longint sum;
		r = '0;
		sum = 0;
		case (op)
			CMD_ADD: begin
				e = lookup(a);
				if (e < 0) begin
					for (e = 0; e < NumEntries; e++)
						if (!trk_valid[e])
							break;
					if (e == NumEntries) begin
						r.status = 1'b1;
						return r;
					end
					trk_valid[e] = 1'b1;
					trk_addr[e] = a;
					ring_first[e] = 0;
					ring_len[e] = 0;
				end
				trim(e, n);
				if (ring_len[e] > 0 && bkt_sec[e][slot(e, ring_len[e] - 1)] == n) begin
					s = slot(e, ring_len[e] - 1);
					if (bkt_hits[e][s] < CountMax)
						bkt_hits[e][s]++;
				end else begin
					if (ring_len[e] >= RingDepth) begin
						ring_first[e] = (ring_first[e] + 1) % RingDepth;
						ring_len[e]--;
					end
					s = slot(e, ring_len[e]);
					bkt_sec[e][s] = n;
					bkt_hits[e][s] = 1;
					ring_len[e]++;
				end
				trk_seen[e] = n;
			end
			CMD_COUNT: begin
				e = lookup(a);
				if (e >= 0) begin
					trim(e, n);
					if (ring_len[e] > 0) begin
						trk_seen[e] = n;
						for (int k = 0; k < ring_len[e]; k++)
							sum += bkt_hits[e][slot(e, k)];
						r.count = (sum > CountMax) ? CountMax[ResultW-1:0] : sum[ResultW-1:0];
					end
				end
			end
			CMD_SWEEP: begin
				for (int i = 0; i < NumEntries; i++)
					if (trk_valid[i] && is_stale(trk_seen[i], n)) begin
						trk_valid[i] = 1'b0;
						ring_first[i] = 0;
						ring_len[i] = 0;
					end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send(input cmd_t op, input logic [AddrW-1:0] a, input logic [TimeW-1:0] n);
		if (burst_left == 0) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		req_ch.valid = 1'b1;
		req_ch.data = {op, a, n};
		do @(posedge clk); while (!req_ch.ready);
		tally_q.push_back(tally_of(op, a, n));
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic set_window(input logic [WinW-1:0] w);
		wait (tally_q.size() == 0);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.data = w;
		do @(posedge clk); while (!cfg_ch.ready);
		win = w;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic random_items(input int n_items);
		int pick;
		cmd_t op;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			op = (pick < 58) ? CMD_ADD : (pick < 85) ? CMD_COUNT : (pick < 95) ? CMD_SWEEP
				: CMD_NOP;
			pick = $urandom_range(0, 99);
			if (pick < 4)
				clock_s = clock_s + $urandom_range(60, 200);
			else if (pick < 7)
				clock_s = clock_s - $urandom_range(1, 5);
			else if (pick < 45)
				clock_s = clock_s + $urandom_range(1, 3);
			send(op, addr_pool[$urandom_range(0, 23)], clock_s);
		end
	endtask

	task automatic test_extremes;
		send(CMD_COUNT, 32'h0, 32'h0);
		send(CMD_ADD, 32'h0, 32'h0);
		send(CMD_ADD, 32'h0, 32'h0);
		send(CMD_COUNT, 32'h0, 32'h0);
		send(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
		send(CMD_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send(CMD_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// time steps back: nothing ages out, a new bucket is appended
		send(CMD_ADD, 32'hFFFF_FFFF, 32'h0000_0005);
		send(CMD_COUNT, 32'hFFFF_FFFF, 32'h0000_0005);
		send(CMD_NOP, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
		send(CMD_COUNT, 32'h1234_5678, 32'h100);
		send(CMD_SWEEP, 32'h0, 32'h200);
		send(CMD_COUNT, 32'h0, 32'h200);
		send(CMD_SWEEP, 32'h0, 32'hFFFF_FFFF);
		send(CMD_COUNT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// more distinct seconds than the ring holds, walking backwards so none expire
	task automatic test_ring_wrap;
		for (int i = 0; i < RingDepth + 3; i++)
			send(CMD_ADD, 32'hC0DE_0001, 32'd5000 - i);
		send(CMD_COUNT, 32'hC0DE_0001, 32'd4000);
		send(CMD_SWEEP, 32'h0, 32'd9000);
	endtask

	task automatic test_table_full;
		for (int i = 0; i < NumEntries + 2; i++)
			send(CMD_ADD, addr_pool[i], 32'd10000);
		send(CMD_COUNT, addr_pool[NumEntries + 1], 32'd10000);
		send(CMD_COUNT, addr_pool[3], 32'd10001);
		send(CMD_SWEEP, 32'h0, 32'd10100);
		send(CMD_ADD, addr_pool[NumEntries + 1], 32'd10100);
		send(CMD_COUNT, addr_pool[NumEntries + 1], 32'd10100);
	endtask

	task automatic test_backpressure;
		hold_cycles = 600;
		random_items(20);
	endtask

	task automatic test_windows;
		logic [WinW-1:0] settings [5] = '{6'd0, 6'd63, 6'd5, 6'd1, WinReset};
		foreach (settings[i]) begin
			set_window(settings[i]);
			random_items(90);
		end
	endtask

	// receiver: alternates steady and choppy ready, with one long hold when asked
	always @(negedge clk) begin
		cycles++;
		if (hold_cycles > 0) begin
			hold_cycles--;
			rsp_ch.ready <= 1'b0;
		end else if ((cycles / 300) % 3 == 1)
			rsp_ch.ready <= 1'b1;
		else
			rsp_ch.ready <= ($urandom_range(0, 2) != 0);
		if (cycles > CycleLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		tally_t got, want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got = rsp_ch.data;
			if (tally_q.size() == 0)
				report("result beat with nothing expected");
			else begin
				want = tally_q[0];
				tally_q.delete(0);
				if (got.count !== want.count)
					report($sformatf("count got %0d want %0d", got.count, want.count));
				if (got.status !== want.status)
					report($sformatf("status got %0b want %0b", got.status, want.status));
			end
		end
	end

	initial begin
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		rsp_ch.ready = 1'b0;
		win = WinReset;
		for (int e = 0; e < NumEntries; e++) begin
			trk_valid[e] = 1'b0;
			ring_first[e] = 0;
			ring_len[e] = 0;
		end
		foreach (addr_pool[i])
			addr_pool[i] = $urandom();
		addr_pool[0] = 32'h0;
		addr_pool[1] = 32'hFFFF_FFFF;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes;
		test_ring_wrap;
		test_table_full;
		test_backpressure;
		test_windows;
		wait (tally_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* sliding_window_request_counter.f */
hw/rtl/swrc_pkg.sv
hw/rtl/swrc_if.sv
hw/rtl/swrc_ctrl.sv
hw/rtl/swrc_dp.sv
hw/rtl/sliding_window_request_counter.sv
tb/sv/sliding_window_request_counter_test.sv
